[rtl/core/avt_pkg.sv]
package avt_pkg;

   // coordinate and coefficient format, signed q16.16
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // full product, product after the fraction shift, and the row accumulator
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
   localparam int SHIFT_WIDTH = PROD_WIDTH - FRAC_BITS;
   localparam int ACC_WIDTH   = SHIFT_WIDTH + 2;

   // matrix layout: three rows of four coefficients
   localparam int ROW_COUNT   = 3;
   localparam int COL_COUNT   = 4;
   localparam int COEF_COUNT  = ROW_COUNT * COL_COUNT;
   localparam int INDEX_WIDTH = 4;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_XFORM = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type                   req_type;
      logic [INDEX_WIDTH-1:0]         coef_index;
      logic signed [COORD_WIDTH-1:0]  coef_value;
      logic signed [COORD_WIDTH-1:0]  vertex_x;
      logic signed [COORD_WIDTH-1:0]  vertex_y;
      logic signed [COORD_WIDTH-1:0]  vertex_z;
   } req_item_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0]  out_x;
      logic signed [COORD_WIDTH-1:0]  out_y;
      logic signed [COORD_WIDTH-1:0]  out_z;
      logic                           saturated;
   } rsp_item_type;

   // pipeline load enables from the top level to each row
   typedef struct packed {
      logic load_prod;
      logic load_out;
   } row_ctrl_type;

endpackage

[rtl/core/affine_vertex_transform_core.sv]
// affine vertex transform core
// holds rows 0 to 2 of a 4x4 transform matrix, twelve signed q16.16 coefficients
// req channel (req_valid / req_ready / req_data) takes one item per handshake:
//   req_type REQ_WRITE stores coef_value at coef_index (row*4+column), no result,
//   indexes 12 to 15 are dropped; REQ_XFORM transforms vertex_x/y/z
// rsp channel (rsp_valid / rsp_ready / rsp_data) returns one item per transform:
//   out = row . (x,y,z) + translation, each product floored by the fraction bits,
//   clamped to 32 bits, saturated set if any component was clamped
// pipeline: input register, product register, result register
// throughput: one item per cycle while rsp_ready is high, set by the three-stage pipeline
//   with one multiplier per scale coefficient; a write enters the same pipe, so a
//   transform accepted after a write sees the new coefficient
// stall: each stage holds while the stage after it is full and stalled, so with
//   rsp_ready low the pipe fills and req_ready drops after three transforms
// reset: coefficients clear to zero and all stages empty
module affine_vertex_transform_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  avt_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output avt_pkg::rsp_item_type rsp_data
);

   localparam int CW = avt_pkg::COORD_WIDTH;
   localparam int RC = avt_pkg::ROW_COUNT;
   localparam int NC = avt_pkg::COL_COUNT;

   // stage valids and the input register
   logic                  s0_valid_ff, s0_valid_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   avt_pkg::req_item_type s0_item_ff;

   // per-stage ready, a stage moves when the next one is empty or moving
   logic ready0, ready1, ready2;
   logic coef_we;

   // coefficient store, packed so each row slice is a fixed wire
   logic [avt_pkg::COEF_COUNT-1:0][CW-1:0] coef_ff;

   avt_pkg::row_ctrl_type row_ctrl;
   logic signed [CW-1:0]  row_value [RC];
   logic [RC-1:0]         row_sat;

   assign ready2 = !rsp_valid_ff || rsp_ready;
   assign ready1 = !s1_valid_ff || ready2;
   assign ready0 = !s0_valid_ff || ready1;

   assign req_ready = ready0;

   // stage valid updates
   always_comb begin
      s0_valid_in  = ready0 ? req_valid : s0_valid_ff;
      s1_valid_in  = ready1 ? (s0_valid_ff && s0_item_ff.req_type == avt_pkg::REQ_XFORM)
                            : s1_valid_ff;
      rsp_valid_in = ready2 ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register takes the item at acceptance
   always_ff @(posedge clock) begin
      if (req_valid && ready0) begin
         s0_item_ff <= req_data;
      end
   end

   // a write commits as it leaves the input register, in order with transforms
   assign coef_we = s0_valid_ff && ready1 && s0_item_ff.req_type == avt_pkg::REQ_WRITE
                    && s0_item_ff.coef_index < avt_pkg::INDEX_WIDTH'(avt_pkg::COEF_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (coef_we) begin
         coef_ff[s0_item_ff.coef_index] <= s0_item_ff.coef_value;
      end
   end

   // transform leaves the input register into the product stage
   assign row_ctrl.load_prod = s0_valid_ff && ready1
                               && s0_item_ff.req_type == avt_pkg::REQ_XFORM;
   assign row_ctrl.load_out  = s1_valid_ff && ready2;

   // one datapath per matrix row
   for (genvar r = 0; r < RC; r++) begin : g_row
      avt_row u_row (
         .clock     (clock),
         .ctrl      (row_ctrl),
         .vertex_x  (s0_item_ff.vertex_x),
         .vertex_y  (s0_item_ff.vertex_y),
         .vertex_z  (s0_item_ff.vertex_z),
         .coef      (coef_ff[r*NC +: NC]),
         .out_value (row_value[r]),
         .out_sat   (row_sat[r])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.out_x     = row_value[0];
   assign rsp_data.out_y     = row_value[1];
   assign rsp_data.out_z     = row_value[2];
   assign rsp_data.saturated = |row_sat;

   // a write item never reaches the product stage
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && ready1 && s0_item_ff.req_type == avt_pkg::REQ_WRITE)
      |=> !s1_valid_ff)
      else $error("write item entered the product stage");

   // a write beyond the matrix leaves the coefficients alone
   a_bad_index_ignored: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && ready1 && s0_item_ff.req_type == avt_pkg::REQ_WRITE
       && s0_item_ff.coef_index >= avt_pkg::INDEX_WIDTH'(avt_pkg::COEF_COUNT))
      |=> $stable(coef_ff))
      else $error("out of range write changed the coefficients");

   // a product stage item moving on always lands in the result register
   a_prod_to_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && ready2) |=> rsp_valid_ff)
      else $error("transform item lost between product and result stage");

endmodule

[rtl/core/avt_row.sv]
module avt_row (
   input  logic                                                 clock,
   input  avt_pkg::row_ctrl_type                                ctrl,
   input  logic signed [avt_pkg::COORD_WIDTH-1:0]               vertex_x,
   input  logic signed [avt_pkg::COORD_WIDTH-1:0]               vertex_y,
   input  logic signed [avt_pkg::COORD_WIDTH-1:0]               vertex_z,
   input  logic [avt_pkg::COL_COUNT-1:0][avt_pkg::COORD_WIDTH-1:0] coef,
   output logic signed [avt_pkg::COORD_WIDTH-1:0]               out_value,
   output logic                                                 out_sat
);

   localparam int CW = avt_pkg::COORD_WIDTH;
   localparam int PW = avt_pkg::PROD_WIDTH;
   localparam int SW = avt_pkg::SHIFT_WIDTH;
   localparam int AW = avt_pkg::ACC_WIDTH;
   localparam int FB = avt_pkg::FRAC_BITS;

   logic signed [PW-1:0] full_x, full_y, full_z;
   logic signed [SW-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [SW-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [CW-1:0] term_ff;
   logic signed [AW-1:0] acc;
   logic [AW-CW:0]       acc_high;
   logic signed [CW-1:0] value_in, value_ff;
   logic                 sat_in, sat_ff;

   // full products, floor shift is a plain select of the upper bits
   assign full_x    = vertex_x * $signed(coef[0]);
   assign full_y    = vertex_y * $signed(coef[1]);
   assign full_z    = vertex_z * $signed(coef[2]);
   assign prod_x_in = full_x[PW-1:FB];
   assign prod_y_in = full_y[PW-1:FB];
   assign prod_z_in = full_z[PW-1:FB];

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         term_ff   <= $signed(coef[3]);
      end
   end

   // exact sum, then clamp to the coordinate range
   assign acc      = AW'(prod_x_ff) + AW'(prod_y_ff) + AW'(prod_z_ff) + AW'(term_ff);
   assign acc_high = acc[AW-1:CW-1];

   always_comb begin
      value_in = acc[CW-1:0];
      sat_in   = 1'b0;
      if (!((&acc_high) || !(|acc_high))) begin
         sat_in   = 1'b1;
         value_in = acc[AW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         value_ff <= value_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_value = value_ff;
   assign out_sat   = sat_ff;

endmodule

[tb/affine_vertex_transform_core_tb.sv]
`timescale 1ns / 100ps

// testbench for the affine vertex transform core
// each accepted item is fed to a transform predictor in acceptance order:
// writes update a local copy of the twelve coefficients, transforms push the
// predicted vertex onto a queue that the result checker pops in order
// test tasks run in turn: directed corners first, then random matrix batches,
// mixed noise, a long receiver hold-off, paused bursts and a stall-free stream
module affine_vertex_transform_core_tb;

   localparam int CLOCK_PERIOD    = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 150;
   localparam int DRAIN_CYCLES    = 8;

   localparam int CW  = avt_pkg::COORD_WIDTH;
   localparam int IW  = avt_pkg::INDEX_WIDTH;
   localparam int NC  = avt_pkg::COL_COUNT;
   localparam int CC  = avt_pkg::COEF_COUNT;

   localparam logic signed [CW-1:0] Q_MAX  = 32'sh7fff_ffff;
   localparam logic signed [CW-1:0] Q_MIN  = 32'sh8000_0000;
   localparam logic signed [CW-1:0] Q_ONE  = 32'sh0001_0000;
   localparam logic signed [CW-1:0] Q_HALF = 32'sh0000_8000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   avt_pkg::req_item_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   avt_pkg::rsp_item_type rsp_data;

   // local copy of the matrix rows, cleared like the block at reset
   logic signed [CW-1:0] coef_model [CC] = '{default: '0};
   // predicted transform results, oldest first
   avt_pkg::rsp_item_type pending_vertices [$];

   int  fail_count     = 0;
   int  cycle_count    = 0;
   bit  req_idle_on    = 1'b1;
   bit  rsp_idle_on    = 1'b1;
   int  hold_off_asked = 0;
   int  hold_off_done  = 0;
   int  rsp_wait       = 0;

   affine_vertex_transform_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // transform predictor
   // ---------------------------------------------------------------------

   // full signed product, floored by the fraction shift
   function automatic longint fixed_mul(input logic signed [CW-1:0] a,
                                        input logic signed [CW-1:0] b);
      return (longint'(a) * longint'(b)) >>> avt_pkg::FRAC_BITS;
   endfunction

   // row dot product plus translation, exact sum, clamp only at the end
   function automatic avt_pkg::rsp_item_type transform_vertex(
      input avt_pkg::req_item_type item);
      avt_pkg::rsp_item_type res;
      longint                acc;
      longint                lim_hi;
      longint                lim_lo;
      logic signed [CW-1:0]  comp [avt_pkg::ROW_COUNT];
      lim_hi = (longint'(1) <<< (CW - 1)) - 1;
      lim_lo = -lim_hi - 1;
      res = '0;
      for (int r = 0; r < avt_pkg::ROW_COUNT; r++) begin
         acc = fixed_mul(item.vertex_x, coef_model[r*NC])
             + fixed_mul(item.vertex_y, coef_model[r*NC + 1])
             + fixed_mul(item.vertex_z, coef_model[r*NC + 2])
             + longint'(coef_model[r*NC + 3]);
         if (acc > lim_hi) begin
            acc = lim_hi;
            res.saturated = 1'b1;
         end else if (acc < lim_lo) begin
            acc = lim_lo;
            res.saturated = 1'b1;
         end
         comp[r] = acc[CW-1:0];
      end
      res.out_x = comp[0];
      res.out_y = comp[1];
      res.out_z = comp[2];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // item builders
   // ---------------------------------------------------------------------

   // q16.16 value: full range, small and mid magnitudes, or a corner value
   function automatic logic signed [CW-1:0] rand_q16();
      logic [31:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 6))
         0, 1: return raw;
         2, 3: return {{14{raw[17]}}, raw[17:0]};
         4:    return {{8{raw[23]}}, raw[23:0]};
         default: begin
            case ($urandom_range(0, 6))
               0: return '0;
               1: return Q_MAX;
               2: return Q_MIN;
               3: return 32'sd1;
               4: return -32'sd1;
               5: return Q_ONE;
               default: return -Q_ONE;
            endcase
         end
      endcase
   endfunction

   // vertex fields of a write are ignored, so they carry noise
   function automatic avt_pkg::req_item_type make_write(input logic [IW-1:0] index,
                                                        input logic signed [CW-1:0] value);
      avt_pkg::req_item_type item;
      item.req_type   = avt_pkg::REQ_WRITE;
      item.coef_index = index;
      item.coef_value = value;
      item.vertex_x   = $urandom;
      item.vertex_y   = $urandom;
      item.vertex_z   = $urandom;
      return item;
   endfunction

   // coefficient fields of a transform are ignored, so they carry noise
   function automatic avt_pkg::req_item_type make_xform(input logic signed [CW-1:0] x,
                                                        input logic signed [CW-1:0] y,
                                                        input logic signed [CW-1:0] z);
      avt_pkg::req_item_type item;
      item.req_type   = avt_pkg::REQ_XFORM;
      item.coef_index = IW'($urandom);
      item.coef_value = $urandom;
      item.vertex_x   = x;
      item.vertex_y   = y;
      item.vertex_z   = z;
      return item;
   endfunction

   function automatic avt_pkg::req_item_type rand_vertex_item();
      return make_xform(rand_q16(), rand_q16(), rand_q16());
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // offers one item and holds it until taken; valid stays high afterwards so
   // that back-to-back items need no second assignment in the same step
   task automatic send_req(input avt_pkg::req_item_type item);
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      // taken at this edge, so the model moves in acceptance order
      if (item.req_type == avt_pkg::REQ_XFORM)
         pending_vertices.push_back(transform_vertex(item));
      else if (item.coef_index < CC)
         coef_model[item.coef_index] = item.coef_value;
   endtask

   // sender stops and waits for every predicted vertex to come back
   task automatic wait_vertices_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_vertices.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   // random stall bursts, plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
      end else if (hold_off_asked != hold_off_done) begin
         hold_off_done <= hold_off_done + 1;
         rsp_ready     <= 1'b0;
         rsp_wait      <= HOLD_OFF_CYCLES - 1;
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin
      avt_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_vertices.pop_front();
            report_field("out_x", want.out_x, rsp_data.out_x);
            report_field("out_y", want.out_y, rsp_data.out_y);
            report_field("out_z", want.out_z, rsp_data.out_z);
            report_field("saturated", CW'(want.saturated), CW'(rsp_data.saturated));
         end
      end
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // matrix cleared by reset: any vertex maps to zero
   task automatic test_reset_matrix();
      send_req(make_xform(Q_MAX, Q_MIN, -32'sd1));
   endtask

   // scale, half scale with floor rounding, negation, extreme translations
   task automatic test_scale_translate();
      send_req(make_write(IW'(0), Q_ONE));
      send_req(make_write(IW'(5), Q_HALF));
      send_req(make_write(IW'(10), -Q_ONE));
      send_req(make_write(IW'(3), 32'sh0003_0000));
      send_req(make_write(IW'(7), -32'sd1));
      send_req(make_write(IW'(11), Q_MIN));
      send_req(make_xform(32'sh0001_8000, -32'sd1, -32'sh0002_0000));
      send_req(make_xform(-32'sd3, 32'sd5, 32'sd1));
      send_req(make_xform(Q_MIN, -32'sd3, Q_MIN));
   endtask

   // writes past the last coefficient are dropped
   task automatic test_index_out_of_range();
      for (int i = CC; i < 16; i++)
         send_req(make_write(IW'(i), Q_MAX));
      send_req(make_xform(32'sh0002_0000, -32'sh0001_4000, 32'sh0000_0100));
   endtask

   // clamp high and low on different rows at once
   task automatic test_saturation();
      send_req(make_write(IW'(0), Q_MAX));
      send_req(make_write(IW'(1), Q_MAX));
      send_req(make_write(IW'(2), Q_MAX));
      send_req(make_write(IW'(4), Q_MIN));
      send_req(make_write(IW'(8), Q_MIN));
      send_req(make_xform(Q_MAX, Q_MAX, Q_MAX));
      send_req(make_xform(Q_MIN, Q_MIN, Q_MIN));
   endtask

   // full matrix load followed by a batch of vertices, random content
   task automatic test_matrix_batches(input int batches);
      for (int b = 0; b < batches; b++) begin
         for (int i = 0; i < CC; i++)
            send_req(make_write(IW'(i), rand_q16()));
         repeat ($urandom_range(6, 14)) send_req(rand_vertex_item());
      end
   endtask

   // any kind, any index, partial matrix updates between vertices
   task automatic test_mixed_noise(input int count);
      avt_pkg::req_item_type item;
      repeat (count) begin
         if ($urandom_range(0, 9) < 4)
            item = make_write($urandom_range(0, 7) == 0 ? IW'($urandom_range(CC, 15))
                                                        : IW'($urandom_range(0, CC - 1)),
                              rand_q16());
         else
            item = rand_vertex_item();
         send_req(item);
      end
   endtask

   // receiver holds off long enough for the pipe to fill and stall the input
   task automatic test_backpressure(input int count);
      hold_off_asked++;
      repeat (count) send_req(rand_vertex_item());
      wait_vertices_drained();
   endtask

   // short bursts with the sender waiting for all results in between
   task automatic test_paused_bursts(input int bursts);
      repeat (bursts) begin
         if ($urandom_range(0, 1) == 0)
            send_req(make_write(IW'($urandom_range(0, CC - 1)), rand_q16()));
         repeat ($urandom_range(10, 18)) send_req(rand_vertex_item());
         wait_vertices_drained();
      end
   endtask

   // no idling on either side, one item per cycle
   task automatic test_streaming(input int count);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      test_matrix_batches(2);
      test_mixed_noise(count);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_matrix();
      test_scale_translate();
      test_index_out_of_range();
      test_saturation();
      wait_vertices_drained();

      test_matrix_batches(40);
      test_mixed_noise(200);
      test_backpressure(60);
      test_paused_bursts(8);
      test_streaming(150);

      // let the pipe empty, then wait out the drain period for anything stray
      wait_vertices_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[affine_vertex_transform_core.f]
rtl/core/avt_pkg.sv
rtl/core/avt_row.sv
rtl/core/affine_vertex_transform_core.sv
tb/affine_vertex_transform_core_tb.sv
